// ----- design/wlrr_pkg.sv -----
// ----------------------------------------------------------------------------
// wlrr_pkg
// Shared constants, codes and types for the wear-levelled record ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wlrr_pkg;

  // store geometry
  localparam int SLOTS_DEFAULT = 256;
  localparam int REC_W         = 128;
  localparam int SLOT_W        = 8;
  localparam int USED_W        = 9;

  // record format and check word
  localparam logic [31:0] MAGIC_WORD = 32'hA5C3F00D;
  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;

  // request kinds
  localparam logic [1:0] REQ_RECOVER = 2'd0;
  localparam logic [1:0] REQ_REPORT  = 2'd1;
  localparam logic [1:0] REQ_PRELOAD = 2'd2;

  // result status codes
  localparam logic [1:0] ST_NONE       = 2'd0;
  localparam logic [1:0] ST_SAVED      = 2'd1;
  localparam logic [1:0] ST_RECOVERED  = 2'd2;
  localparam logic [1:0] ST_NONE_VALID = 2'd3;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SAVE_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE  = 1'd1;

  // status of the check word unit
  typedef struct packed {
    logic busy;
    logic done;
  } fnv_stat_t;

endpackage

// ----- design/wear_leveled_record_ring_core.sv -----
// ----------------------------------------------------------------------------
// wear_leveled_record_ring_core
// Ring of 16-byte runtime records with recovery scan and wear-levelled saves.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every slot of the record
// store and takes no request meanwhile (configuration writes are still
// accepted). One request is handled at a time. The check word is produced one
// byte per cycle by a shared FNV-1a unit, sixteen steps a record. A recover
// request takes, for each slot in use, one RAM read, one load, sixteen hash
// steps and a decision. A report that does not save, a preload and an unknown
// request go from dispatch straight to the result. The ring position for a
// save is found by repeated subtraction, which adds steps only when the
// slot after the newest lies at or beyond the slots in use. A result sits in
// an output register, so it may wait for out_ready while the block goes back
// to idle.
`timescale 1ns / 1ps

module wear_leveled_record_ring_core #(
  parameter int SLOTS = wlrr_pkg::SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_req_type,
  input  logic [31:0]                    in_minutes_now,
  input  logic [7:0]                     in_slot_index,
  input  logic [31:0]                    in_raw_magic,
  input  logic [31:0]                    in_raw_sequence,
  input  logic [31:0]                    in_raw_minutes,
  input  logic [31:0]                    in_raw_check,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [7:0]                     out_current_slot,
  output logic [31:0]                    out_current_sequence,
  output logic [31:0]                    out_record_minutes,
  output logic [31:0]                    out_record_check,
  // configuration
  input  logic                           cfg_we,
  input  logic [wlrr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wlrr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wlrr_pkg::*;

  localparam int AW  = $clog2(SLOTS);
  localparam int LIM = (SLOTS < 256) ? SLOTS : 256;

  // sequencer states
  localparam logic [2:0] S_CLEAR     = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_DISPATCH  = 3'd2;
  localparam logic [2:0] S_SCAN_RD   = 3'd3;
  localparam logic [2:0] S_SCAN_LD   = 3'd4;
  localparam logic [2:0] S_SCAN_HASH = 3'd5;
  localparam logic [2:0] S_SAVE_RUN  = 3'd6;
  localparam logic [2:0] S_FINISH    = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;

  // captured request
  logic [1:0]        req_r;
  logic [31:0]       now_r;
  logic [7:0]        idx_r;
  logic [31:0]       raw_magic_r, raw_seq_r, raw_min_r, raw_check_r;

  // scan and save working registers
  logic [SLOT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic              found_r, found_nxt;
  logic [31:0]       top_seq_r, top_seq_nxt;
  logic [31:0]       top_min_r, top_min_nxt;
  logic [SLOT_W-1:0] top_slot_r, top_slot_nxt;
  logic [USED_W-1:0] mod_r, mod_nxt;

  // ring state
  logic [SLOT_W-1:0] newest_slot_r, newest_slot_nxt;
  logic [31:0]       newest_seq_r, newest_seq_nxt;
  logic [31:0]       last_min_r, last_min_nxt;

  // pending result
  logic [1:0]        res_status_r, res_status_nxt;
  logic [31:0]       res_mins_r, res_mins_nxt;
  logic [31:0]       res_check_r, res_check_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [7:0]        out_slot_r, out_slot_nxt;
  logic [31:0]       out_seq_r, out_seq_nxt;
  logic [31:0]       out_mins_r, out_mins_nxt;
  logic [31:0]       out_check_r, out_check_nxt;

  // configuration registers
  logic [15:0]       cfg_interval_r, cfg_interval_nxt;
  logic [USED_W-1:0] cfg_slots_r, cfg_slots_nxt;

  // store and hash unit
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [REC_W-1:0]  ram_wdata, ram_rdata_r;
  logic              fnv_start;
  logic [31:0]       fnv_magic, fnv_seq, fnv_min, fnv_hash_r;
  fnv_stat_t         fnv_stat;

  logic [USED_W-1:0] n_used;
  logic [31:0]       seq_plus;
  logic              in_xfer, rec_ok, rec_better, scan_last;

  wlrr_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata_r)
  );

  wlrr_fnv u_fnv (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (fnv_start),
    .magic      (fnv_magic),
    .sequence_w (fnv_seq),
    .minutes    (fnv_min),
    .stat       (fnv_stat),
    .hash_r     (fnv_hash_r)
  );

  // slots in use, clamped to the store
  always_comb begin
    if (cfg_slots_r == '0) begin
      n_used = USED_W'(1);
    end else if (cfg_slots_r > USED_W'(LIM)) begin
      n_used = USED_W'(LIM);
    end else begin
      n_used = cfg_slots_r;
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign seq_plus   = newest_seq_r + 32'd1;
  assign rec_ok     = (ram_rdata_r[31:0] == MAGIC_WORD) && (fnv_hash_r == ram_rdata_r[127:96]);
  assign rec_better = !found_r || (ram_rdata_r[63:32] > top_seq_r);
  assign scan_last  = ({1'b0, scan_idx_r} == (n_used - USED_W'(1)));

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    clr_cnt_nxt      = clr_cnt_r;
    scan_idx_nxt     = scan_idx_r;
    found_nxt        = found_r;
    top_seq_nxt      = top_seq_r;
    top_min_nxt      = top_min_r;
    top_slot_nxt     = top_slot_r;
    mod_nxt          = mod_r;
    newest_slot_nxt  = newest_slot_r;
    newest_seq_nxt   = newest_seq_r;
    last_min_nxt     = last_min_r;
    res_status_nxt   = res_status_r;
    res_mins_nxt     = res_mins_r;
    res_check_nxt    = res_check_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_slot_nxt     = out_slot_r;
    out_seq_nxt      = out_seq_r;
    out_mins_nxt     = out_mins_r;
    out_check_nxt    = out_check_r;
    cfg_interval_nxt = cfg_interval_r;
    cfg_slots_nxt    = cfg_slots_r;
    ram_we           = 1'b0;
    ram_waddr        = AW'(idx_r);
    ram_wdata        = {raw_check_r, raw_min_r, raw_seq_r, raw_magic_r};
    ram_re           = 1'b0;
    ram_raddr        = AW'(scan_idx_r);
    fnv_start        = 1'b0;
    fnv_magic        = MAGIC_WORD;
    fnv_seq          = seq_plus;
    fnv_min          = now_r;

    // result drains independently of the sequencer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        CFG_SAVE_INTERVAL: cfg_interval_nxt = cfg_wdata;
        CFG_SLOTS_IN_USE:  cfg_slots_nxt    = cfg_wdata[USED_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      // zero the store after reset
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_DISPATCH;
        end
      end

      // decide what the captured request does
      S_DISPATCH: begin
        res_status_nxt = ST_NONE;
        res_mins_nxt   = '0;
        res_check_nxt  = '0;
        case (req_r)
          REQ_RECOVER: begin
            scan_idx_nxt = '0;
            found_nxt    = 1'b0;
            top_seq_nxt  = '0;
            top_min_nxt  = '0;
            top_slot_nxt = '0;
            state_nxt    = S_SCAN_RD;
          end
          REQ_REPORT: begin
            if ((now_r - last_min_r) >= {16'd0, cfg_interval_r}) begin
              fnv_start = 1'b1;
              mod_nxt   = {1'b0, newest_slot_r} + USED_W'(1);
              state_nxt = S_SAVE_RUN;
            end else begin
              res_mins_nxt = last_min_r;
              state_nxt    = S_FINISH;
            end
          end
          REQ_PRELOAD: begin
            ram_we    = ({24'd0, idx_r} < 32'(SLOTS));
            state_nxt = S_FINISH;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end

      S_SCAN_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_SCAN_LD;
      end

      S_SCAN_LD: begin
        fnv_start = 1'b1;
        fnv_magic = ram_rdata_r[31:0];
        fnv_seq   = ram_rdata_r[63:32];
        fnv_min   = ram_rdata_r[95:64];
        state_nxt = S_SCAN_HASH;
      end

      // judge one slot, keep the earliest highest sequence
      S_SCAN_HASH: begin
        if (fnv_stat.done) begin
          if (rec_ok && rec_better) begin
            found_nxt    = 1'b1;
            top_seq_nxt  = ram_rdata_r[63:32];
            top_min_nxt  = ram_rdata_r[95:64];
            top_slot_nxt = scan_idx_r;
          end
          if (scan_last) begin
            newest_slot_nxt = top_slot_nxt;
            newest_seq_nxt  = top_seq_nxt;
            last_min_nxt    = top_min_nxt;
            res_mins_nxt    = top_min_nxt;
            res_status_nxt  = found_nxt ? ST_RECOVERED : ST_NONE_VALID;
            state_nxt       = S_FINISH;
          end else begin
            scan_idx_nxt = scan_idx_r + SLOT_W'(1);
            state_nxt    = S_SCAN_RD;
          end
        end
      end

      // reduce the ring position while the check word is formed
      S_SAVE_RUN: begin
        if (mod_r >= n_used) begin
          mod_nxt = mod_r - n_used;
        end else if (!fnv_stat.busy) begin
          ram_we          = 1'b1;
          ram_waddr       = AW'(mod_r[SLOT_W-1:0]);
          ram_wdata       = {fnv_hash_r, now_r, seq_plus, MAGIC_WORD};
          newest_slot_nxt = mod_r[SLOT_W-1:0];
          newest_seq_nxt  = seq_plus;
          last_min_nxt    = now_r;
          res_mins_nxt    = now_r;
          res_check_nxt   = fnv_hash_r;
          res_status_nxt  = ST_SAVED;
          state_nxt       = S_FINISH;
        end
      end

      // hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = newest_slot_r;
          out_seq_nxt    = newest_seq_r;
          out_mins_nxt   = res_mins_r;
          out_check_nxt  = res_check_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      newest_slot_r  <= '0;
      newest_seq_r   <= '0;
      last_min_r     <= '0;
      out_valid_r    <= 1'b0;
      cfg_interval_r <= 16'd1;
      cfg_slots_r    <= USED_W'(256);
    end else begin
      state_r        <= state_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      newest_slot_r  <= newest_slot_nxt;
      newest_seq_r   <= newest_seq_nxt;
      last_min_r     <= last_min_nxt;
      out_valid_r    <= out_valid_nxt;
      cfg_interval_r <= cfg_interval_nxt;
      cfg_slots_r    <= cfg_slots_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r       <= in_req_type;
      now_r       <= in_minutes_now;
      idx_r       <= in_slot_index;
      raw_magic_r <= in_raw_magic;
      raw_seq_r   <= in_raw_sequence;
      raw_min_r   <= in_raw_minutes;
      raw_check_r <= in_raw_check;
    end
    scan_idx_r   <= scan_idx_nxt;
    found_r      <= found_nxt;
    top_seq_r    <= top_seq_nxt;
    top_min_r    <= top_min_nxt;
    top_slot_r   <= top_slot_nxt;
    mod_r        <= mod_nxt;
    res_status_r <= res_status_nxt;
    res_mins_r   <= res_mins_nxt;
    res_check_r  <= res_check_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_seq_r    <= out_seq_nxt;
    out_mins_r   <= out_mins_nxt;
    out_check_r  <= out_check_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_current_slot     = out_slot_r;
  assign out_current_sequence = out_seq_r;
  assign out_record_minutes   = out_mins_r;
  assign out_record_check     = out_check_r;

endmodule

// ----- design/wlrr_ram.sv -----
// ----------------------------------------------------------------------------
// wlrr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wlrr_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- design/wlrr_fnv.sv -----
// ----------------------------------------------------------------------------
// wlrr_fnv
// Byte-serial FNV-1a 32 check word over a packed record, check field as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wlrr_fnv (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         magic,
  input  logic [31:0]         sequence_w,
  input  logic [31:0]         minutes,
  output wlrr_pkg::fnv_stat_t stat,
  output logic [31:0]         hash_r
);
  import wlrr_pkg::*;

  logic [95:0] sh_r, sh_nxt;
  logic [31:0] hash_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] hx;

  // one byte per cycle: little-endian bytes leave the bottom, zeros enter the top
  always_comb begin
    sh_nxt   = sh_r;
    hash_nxt = hash_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    hx       = hash_r ^ {24'd0, sh_r[7:0]};
    if (start) begin
      sh_nxt   = {minutes, sequence_w, magic};
      hash_nxt = FNV_OFFSET;
      cnt_nxt  = 4'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hash_nxt = hx * FNV_PRIME;
      sh_nxt   = {8'd0, sh_r[95:8]};
      cnt_nxt  = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    hash_r <= hash_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- design/wlrr_checker.sv -----
// ----------------------------------------------------------------------------
// wlrr_checker
// Port-level checks on the record ring core, bound to every instance of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wlrr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [7:0]  out_current_slot,
  input logic [31:0] out_current_sequence,
  input logic [31:0] out_record_minutes,
  input logic [31:0] out_record_check
);
  import wlrr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_current_sequence) && $stable(out_record_check))
    else $error("stalled result changed");

  // one request at a time: ready drops after every transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // only a save carries a check word
  a_check_only_saved: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_SAVED) |-> out_record_check == 32'd0)
    else $error("check word on a result that saved nothing");

  // nothing valid on recovery clears the ring position
  a_none_valid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NONE_VALID) |->
    (out_current_slot == 8'd0) && (out_current_sequence == 32'd0) &&
    (out_record_minutes == 32'd0))
    else $error("empty recovery left a non-zero position");

  // reset empties the output and blocks requests
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("activity straight after reset");

endmodule

bind wear_leveled_record_ring_core wlrr_checker u_wlrr_checker (.*);
